/* rtl/assert_macros.svh */
// Assertion macros shared by the cursor list buffer RTL.
// Clocked, reset-qualified property checks reporting through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define CLB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("cursor list buffer check failed");

// Condition must never be seen outside reset.
`define CLB_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `CLB_ASSERT(lbl, clk, rstn, !(cond))

`endif

/* rtl/clb_pkg.sv */
// Package for the cursor list buffer: sizes, command and status codes,
// item structs and the controller/datapath interface structs. No dependencies.
package clb_pkg;

  localparam int CAPACITY   = 64;
  localparam int ELEM_WIDTH = 32;
  localparam int VAL_W      = 32;
  localparam int POS_W      = 7;
  localparam int ACT_W      = 4;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR  = 4'd0,
    ACT_START  = 4'd1,
    ACT_END    = 4'd2,
    ACT_NEXT   = 4'd3,
    ACT_PREV   = 4'd4,
    ACT_READ   = 4'd5,
    ACT_INSERT = 4'd6,
    ACT_APPEND = 4'd7,
    ACT_REMOVE = 4'd8,
    ACT_MOVE   = 4'd9
  } action_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_END  = 2'd1,
    ST_FULL = 2'd2,
    ST_POS  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH,
    S_SH_RD,
    S_SH_WR,
    S_INS_PUT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } cmd_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value_out;
    logic [POS_W-1:0]        cursor;
    logic [POS_W-1:0]        length;
    status_e                 status;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    logic    exec_simple;
    logic    rd_cur;
    logic    rd_shift;
    logic    wr_shift;
    logic    wr_put;
    logic    wr_app;
    logic    capture;
    logic    idx_up_init;
    logic    idx_dn_init;
    logic    idx_step;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    set_err;
    status_e err_code;
    logic    out_load;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    action_e action;
    logic    cur_lt_cnt;
    logic    full;
    logic    shift_more;
    logic    out_busy;
  } sts_t;

endpackage

/* rtl/clb_ctrl.sv */
// Cursor list buffer controller: sequences one item through decode,
// element fetch, shift loop and result load. Uses clb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module clb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  clb_pkg::sts_t sts_i,
  output clb_pkg::ctl_t ctl_o
);
  import clb_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        case (sts_i.action) inside
          ACT_READ, ACT_REMOVE: state_d = sts_i.cur_lt_cnt ? S_FETCH : S_DONE;
          ACT_INSERT:           state_d = sts_i.full ? S_DONE : S_SH_RD;
          default:              state_d = S_DONE;
        endcase
      end
      S_FETCH: begin
        state_d = (sts_i.action == ACT_REMOVE) ? S_SH_RD : S_DONE;
      end
      S_SH_RD: begin
        if (sts_i.shift_more) begin
          state_d = S_SH_WR;
        end else if (sts_i.action == ACT_INSERT) begin
          state_d = S_INS_PUT;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SH_WR:   state_d = S_SH_RD;
      S_INS_PUT: state_d = S_DONE;
      S_DONE: begin
        if (!sts_i.out_busy) state_d = S_IDLE;
      end
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctl_o      = '0;
    in_stall_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: ctl_o.load = in_valid_i;
      S_EXEC: begin
        case (sts_i.action) inside
          ACT_READ, ACT_REMOVE: begin
            if (sts_i.cur_lt_cnt) begin
              ctl_o.rd_cur = 1'b1;
            end else begin
              ctl_o.set_err  = 1'b1;
              ctl_o.err_code = ST_END;
            end
          end
          ACT_INSERT: begin
            if (sts_i.full) begin
              ctl_o.set_err  = 1'b1;
              ctl_o.err_code = ST_FULL;
            end else begin
              ctl_o.idx_up_init = 1'b1;
            end
          end
          ACT_APPEND: begin
            if (sts_i.full) begin
              ctl_o.set_err  = 1'b1;
              ctl_o.err_code = ST_FULL;
            end else begin
              ctl_o.wr_app  = 1'b1;
              ctl_o.cnt_inc = 1'b1;
            end
          end
          default: ctl_o.exec_simple = 1'b1;
        endcase
      end
      S_FETCH: begin
        ctl_o.capture     = 1'b1;
        ctl_o.idx_dn_init = (sts_i.action == ACT_REMOVE);
      end
      S_SH_RD: begin
        if (sts_i.shift_more) begin
          ctl_o.rd_shift = 1'b1;
        end else if (sts_i.action != ACT_INSERT) begin
          ctl_o.cnt_dec = 1'b1;
        end
      end
      S_SH_WR: begin
        ctl_o.wr_shift = 1'b1;
        ctl_o.idx_step = 1'b1;
      end
      S_INS_PUT: begin
        ctl_o.wr_put  = 1'b1;
        ctl_o.cnt_inc = 1'b1;
      end
      S_DONE: ctl_o.out_load = !sts_i.out_busy;
      default: ctl_o = '0;
    endcase
  end

  `CLB_ASSERT(a_one_mem_write, clk_i, rst_ni, $onehot0({ctl_o.wr_shift, ctl_o.wr_put, ctl_o.wr_app}))
  `CLB_ASSERT(a_write_follows_read, clk_i, rst_ni, (state_q == S_SH_WR) |-> ($past(state_q) == S_SH_RD))
  `CLB_ASSERT_NEVER(a_no_count_race, clk_i, rst_ni, ctl_o.cnt_inc && ctl_o.cnt_dec)

endmodule

/* rtl/clb_dp.sv */
// Cursor list buffer datapath: element memory, cursor/count registers,
// shift index, result and output register. Uses clb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module clb_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  clb_pkg::cmd_t cmd_i,
  input  clb_pkg::ctl_t ctl_i,
  output clb_pkg::sts_t sts_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output clb_pkg::res_t out_data_o
);
  import clb_pkg::*;

  logic [ELEM_WIDTH-1:0] mem [CAPACITY];

  action_e               act_q;
  logic [ELEM_WIDTH-1:0] val_q;
  logic [POS_W-1:0]      pos_q;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      cursor_q, cursor_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic [ELEM_WIDTH-1:0] rdata_q;
  logic [ELEM_WIDTH-1:0] res_q, res_d;
  status_e               status_q, status_d;
  logic                  out_valid_q;
  res_t                  out_data_q;

  logic                  shift_up;
  logic [CNT_W-1:0]      idx_m1, idx_p1;
  logic                  mem_re, mem_we;
  logic [ADDR_W-1:0]     raddr, waddr;
  logic [ELEM_WIDTH-1:0] wdata;

  assign shift_up = (act_q == ACT_INSERT);
  assign idx_m1   = idx_q - 1'b1;
  assign idx_p1   = idx_q + 1'b1;

  assign sts_o.action     = act_q;
  assign sts_o.cur_lt_cnt = (cursor_q < count_q);
  assign sts_o.full       = (count_q >= CNT_W'(CAPACITY));
  assign sts_o.shift_more = shift_up ? (idx_q > cursor_q) : (idx_p1 < count_q);
  assign sts_o.out_busy   = out_valid_q & out_stall_i;

  // memory ports
  assign mem_re = ctl_i.rd_cur | ctl_i.rd_shift;
  assign raddr  = ctl_i.rd_cur ? cursor_q[ADDR_W-1:0]
                : (shift_up ? idx_m1[ADDR_W-1:0] : idx_p1[ADDR_W-1:0]);
  assign mem_we = ctl_i.wr_shift | ctl_i.wr_put | ctl_i.wr_app;
  assign waddr  = ctl_i.wr_shift ? idx_q[ADDR_W-1:0]
                : (ctl_i.wr_put ? cursor_q[ADDR_W-1:0] : count_q[ADDR_W-1:0]);
  assign wdata  = ctl_i.wr_shift ? rdata_q : val_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= wdata;
    if (mem_re) rdata_q <= mem[raddr];
  end

  always_comb begin
    count_d  = count_q;
    cursor_d = cursor_q;
    status_d = status_q;
    res_d    = res_q;
    idx_d    = idx_q;

    if (ctl_i.load) begin
      status_d = ST_OK;
      res_d    = '0;
    end
    if (ctl_i.set_err) status_d = ctl_i.err_code;
    if (ctl_i.capture) res_d = rdata_q;

    if (ctl_i.exec_simple) begin
      case (act_q)
        ACT_CLEAR: begin
          count_d  = '0;
          cursor_d = '0;
        end
        ACT_START: cursor_d = '0;
        ACT_END:   cursor_d = count_q;
        ACT_NEXT: begin
          if (cursor_q < count_q) cursor_d = cursor_q + 1'b1;
        end
        ACT_PREV: begin
          if (cursor_q != '0) cursor_d = cursor_q - 1'b1;
        end
        ACT_MOVE: begin
          if (CNT_W'(pos_q) <= count_q) begin
            cursor_d = CNT_W'(pos_q);
          end else begin
            status_d = ST_POS;
          end
        end
        default: ;
      endcase
    end

    if (ctl_i.cnt_inc) count_d = count_q + 1'b1;
    if (ctl_i.cnt_dec) count_d = count_q - 1'b1;

    if (ctl_i.idx_up_init) idx_d = count_q;
    if (ctl_i.idx_dn_init) idx_d = cursor_q;
    if (ctl_i.idx_step)    idx_d = shift_up ? idx_m1 : idx_p1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      cursor_q <= cursor_d;
      if (ctl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      act_q <= action_e'(cmd_i.action);
      val_q <= cmd_i.value[ELEM_WIDTH-1:0];
      pos_q <= cmd_i.position;
    end
    idx_q    <= idx_d;
    res_q    <= res_d;
    status_q <= status_d;
    if (ctl_i.out_load) begin
      out_data_q.value_out <= VAL_W'($signed(res_q));
      out_data_q.cursor    <= POS_W'(cursor_q);
      out_data_q.length    <= POS_W'(count_q);
      out_data_q.status    <= status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `CLB_ASSERT(a_cursor_in_list, clk_i, rst_ni, cursor_q <= count_q)
  `CLB_ASSERT(a_count_bounded, clk_i, rst_ni, count_q <= CNT_W'(CAPACITY))
  `CLB_ASSERT(a_no_grow_when_full, clk_i, rst_ni, ctl_i.cnt_inc |-> !sts_o.full)

endmodule

/* rtl/cursor_list_buffer.sv */
// From accept to result: clear, cursor moves and append only execute; read adds an
// element fetch, remove a fetch and a shift loop, insert a shift loop and a put.
// One item at a time: the next item is taken the cycle after the result is loaded.
// Reset (async, active low) empties the list and zeroes the cursor; element memory
// is not cleared and needs no clearing pass.
module cursor_list_buffer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  clb_pkg::cmd_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output clb_pkg::res_t out_data_o
);
  import clb_pkg::*;

  ctl_t ctl;
  sts_t sts;

  clb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  clb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (in_data_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
